@@ rtl/b64e_pkg.sv @@
package b64e_pkg;

    localparam int B64E_QUEUE_DEPTH = 2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    localparam logic [1:0] SEXTET_0 = 2'd0;
    localparam logic [1:0] SEXTET_1 = 2'd1;
    localparam logic [1:0] SEXTET_2 = 2'd2;
    localparam logic [1:0] SEXTET_3 = 2'd3;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [1:0] pads;
        logic       last;
    } t_group;

    function automatic logic [6:0] sym_to_ascii(input logic [5:0] sym);
        logic [6:0] wide;
        wide = {1'b0, sym};
        if (sym < 6'd26) begin
            return 7'h41 + wide;
        end else if (sym < 6'd52) begin
            return 7'h61 + wide - 7'd26;
        end else if (sym < 6'd62) begin
            return 7'h30 + wide - 7'd52;
        end else if (sym == 6'd62) begin
            return 7'h2D;
        end else begin
            return 7'h5F;
        end
    endfunction

endpackage

@@ rtl/b64e_ifs.sv @@
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

@@ rtl/base64_url_alphabet_encoder.sv @@
// Base64url encoder with '=' padding. Bytes enter on i_in, one per cycle while the group
// queue has room; o_out gives one ASCII character per cycle while groups are queued and the
// receiver is ready, the URL-safe alphabet with '-' and '_' for symbols 62 and 63, and
// last_char marks the final character of a message. Every third byte, or a final byte, yields
// four characters, so the single-character output port sets the sustained rate. The first
// character of a group is offered on o_out once the group has been written to the queue,
// loaded into the group register and its first character registered in the output register.
module base64_url_alphabet_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64e_in_if.sink    i_in,
    b64e_out_if.source o_out
);
    import b64e_pkg::*;

    t_group push_group;
    t_group head_group;
    logic   push;
    logic   full;
    logic   pop;
    logic   empty;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_group (push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_group (head_group)
    );

    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_group (head_group),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ rtl/b64e_front.sv @@
module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b64e_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output b64e_pkg::t_group o_group
);
    import b64e_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [7:0] r_held0;
    logic [7:0] n_held0;
    logic [7:0] r_held1;
    logic [7:0] n_held1;
    logic       accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        n_cnt   = r_cnt;
        n_held0 = r_held0;
        n_held1 = r_held1;
        o_push  = 1'b0;
        o_group = '0;
        if (accept) begin
            if (r_cnt[1]) begin
                o_push  = 1'b1;
                o_group = '{byte_a: r_held0, byte_b: r_held1, byte_c: i_in.in_byte,
                            pads: PAD_NONE, last: i_in.end_of_message};
                n_cnt   = 2'd0;
            end else if (i_in.end_of_message) begin
                o_push = 1'b1;
                if (r_cnt == 2'd0) begin
                    o_group = '{byte_a: i_in.in_byte, byte_b: 8'd0, byte_c: 8'd0,
                                pads: PAD_TWO, last: 1'b1};
                end else begin
                    o_group = '{byte_a: r_held0, byte_b: i_in.in_byte, byte_c: 8'd0,
                                pads: PAD_ONE, last: 1'b1};
                end
                n_cnt = 2'd0;
            end else begin
                if (r_cnt == 2'd0) begin
                    n_held0 = i_in.in_byte;
                end else begin
                    n_held1 = i_in.in_byte;
                end
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

endmodule

@@ rtl/b64e_queue.sv @@
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_group i_group,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output b64e_pkg::t_group o_group
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_group = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/b64e_back.sv @@
module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  b64e_pkg::t_group i_group,
    output logic             o_pop,
    b64e_out_if.source       o_out
);
    import b64e_pkg::*;

    t_group     r_grp;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       load;
    logic       at_end;
    logic [5:0] sextet;
    logic [6:0] n_char;
    logic       n_last;

    assign load   = r_busy && (!r_valid || o_out.ready);
    assign at_end = (r_idx == SEXTET_3);
    assign o_pop  = !i_empty && (!r_busy || (load && at_end));

    always_comb begin
        n_last = 1'b0;
        unique case (r_idx)
            SEXTET_0: sextet = r_grp.byte_a[7:2];
            SEXTET_1: sextet = {r_grp.byte_a[1:0], r_grp.byte_b[7:4]};
            SEXTET_2: sextet = {r_grp.byte_b[3:0], r_grp.byte_c[7:6]};
            default:  sextet = r_grp.byte_c[5:0];
        endcase
        n_char = sym_to_ascii(sextet);
        if (r_idx == SEXTET_2 && r_grp.pads == PAD_TWO) begin
            n_char = PAD_CHAR;
        end
        if (at_end) begin
            n_last = r_grp.last;
            if (r_grp.pads != PAD_NONE) begin
                n_char = PAD_CHAR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= SEXTET_0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= SEXTET_0;
            end else if (load && at_end) begin
                r_busy <= 1'b0;
            end else if (load) begin
                r_idx <= r_idx + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (load) begin
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_char  = r_char;
    assign o_out.last_char = r_last;

endmodule

@@ rtl/b64e_chk.sv @@
module b64e_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_last
);
    import b64e_pkg::*;

    logic char_ok;

    assign char_ok = (i_out_char >= 7'h41 && i_out_char <= 7'h5A)
                  || (i_out_char >= 7'h61 && i_out_char <= 7'h7A)
                  || (i_out_char >= 7'h30 && i_out_char <= 7'h39)
                  || (i_out_char == 7'h2D) || (i_out_char == 7'h5F)
                  || (i_out_char == PAD_CHAR);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("outputs not idle after reset");

    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> char_ok)
        else $error("character outside the url-safe alphabet");

    a_pad_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_char == PAD_CHAR && !i_out_last
        |=> i_out_valid && i_out_char == PAD_CHAR)
        else $error("padding not followed by padding");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("stalled word changed");

endmodule

bind base64_url_alphabet_encoder b64e_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last_char)
);
